// ===== rtl/ssri_pkg.sv =====
`default_nettype none
package ssri_pkg;

    // widths fixed by the record and result formats
    localparam int CNT_W    = 23;
    localparam int ID_SLOTS = 8;
    localparam int DIV_N_W  = 86;
    localparam int DIV_D_W  = 46;
    localparam int STEP_W   = 7;
    localparam int SQ_W     = 50;

    localparam logic [CNT_W-1:0] CNT_MAX = 23'h7FFFFF;
    localparam logic [16:0]      ONE_Q16 = 17'h10000;

    // 1.96^2 = 2401/625, and 625*256 folded into one scale
    localparam logic [11:0] WALD_MUL  = 12'd2401;
    localparam logic [17:0] WALD_DIV  = 18'd160000;
    localparam logic [16:0] EXT_SCALE = 17'd100000;

    // register indexes
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_COUNT    = 2'd1;
    localparam logic [1:0] CFG_IDS      = 2'd2;

    typedef struct packed {
        logic [7:0] scenario_number;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [6:0]       checkpoint_index;
        logic [CNT_W-1:0] records_seen;
        logic [2:0]       slot;
        logic [16:0]      share;
        logic [16:0]      share_low;
        logic [16:0]      share_high;
        logic             last_of_checkpoint;
    } out_item_t;

    // snapshot of one checkpoint handed to the back end
    typedef struct packed {
        logic [ID_SLOTS-1:0][CNT_W-1:0] counts;
        logic [CNT_W-1:0]               total;
        logic [15:0]                    interval;
        logic [6:0]                     index;
        logic [3:0]                     slots;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/ssri_queue.sv =====
`default_nettype none
module ssri_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ssri_pkg::job_t push_job,
    input  wire logic          pop,
    output ssri_pkg::job_t     head,
    output logic               full,
    output logic               empty
);

    ssri_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    // pointer and fill bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);

endmodule
`default_nettype wire

// ===== rtl/ssri_front.sv =====
`default_nettype none
module ssri_front #(
    parameter int MAX_SCENARIOS = 8,
    parameter int CHECKPOINTS   = 100
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire ssri_pkg::in_item_t item,
    input  wire logic [15:0]        interval,
    input  wire logic [3:0]         scenario_count,
    input  wire logic [63:0]        scenario_ids,
    output logic                    push,
    output ssri_pkg::job_t          push_job
);

    localparam int NSLOT  = (MAX_SCENARIOS < ssri_pkg::ID_SLOTS) ? MAX_SCENARIOS
                                                                 : ssri_pkg::ID_SLOTS;
    localparam int DONE_W = $clog2(CHECKPOINTS + 1);
    localparam int THR_W  = 16 + DONE_W;
    localparam int CMP_W  = (THR_W > ssri_pkg::CNT_W) ? THR_W : ssri_pkg::CNT_W;

    logic [NSLOT-1:0][ssri_pkg::CNT_W-1:0] counts_reg, counts_next;
    logic [ssri_pkg::CNT_W-1:0]            total_reg, total_next;
    logic [DONE_W-1:0]                     done_reg, done_next;

    logic [3:0]              slots;
    logic [15:0]             iv;
    logic [THR_W-1:0]        threshold;
    logic [DONE_W-1:0]       done_base;
    logic                    stopped;
    logic                    fire;
    logic                    hit;

    assign slots = (scenario_count > 4'(NSLOT)) ? 4'(NSLOT) : scenario_count;
    assign iv    = (interval == 16'd0) ? 16'd1 : interval;

    // counting of one record
    always_comb
    begin
        counts_next = counts_reg;
        total_next  = total_reg;
        done_base   = done_reg;
        if (item.first)
        begin
            counts_next = '0;
            total_next  = '0;
            done_base   = '0;
        end
        done_next = done_base;
        stopped   = (done_base >= DONE_W'(CHECKPOINTS));
        hit       = 1'b0;
        threshold = THR_W'(iv) * THR_W'({1'b0, done_base} + 1'b1);
        fire      = 1'b0;
        if (!stopped)
        begin
            if (total_next != ssri_pkg::CNT_MAX)
                total_next = total_next + 1'b1;
            // lowest matching slot in use takes the count
            for (int s = 0; s < NSLOT; s++)
            begin
                if (!hit && (4'(s) < slots) && (scenario_ids[8*s +: 8] == item.scenario_number))
                begin
                    hit = 1'b1;
                    if (counts_next[s] != ssri_pkg::CNT_MAX)
                        counts_next[s] = counts_next[s] + 1'b1;
                end
            end
            fire = (CMP_W'(total_next) >= CMP_W'(threshold));
            if (fire)
                done_next = done_base + 1'b1;
        end
    end

    // checkpoint snapshot
    always_comb
    begin
        push_job          = '0;
        for (int s = 0; s < NSLOT; s++)
            push_job.counts[s] = counts_next[s];
        push_job.total    = total_next;
        push_job.interval = iv;
        push_job.index    = 7'(done_base);
        push_job.slots    = slots;
    end

    assign push = accept && fire && (slots != 4'd0);

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
            total_reg  <= '0;
            done_reg   <= '0;
        end
        else if (accept)
        begin
            counts_reg <= counts_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ssri_div.sv =====
`default_nettype none
module ssri_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [ssri_pkg::DIV_N_W-1:0]    dividend,
    input  wire logic [ssri_pkg::DIV_D_W-1:0]    divisor,
    input  wire logic [ssri_pkg::STEP_W-1:0]     steps,
    output logic                                 busy,
    output logic [ssri_pkg::DIV_N_W-1:0]         quotient
);

    logic [ssri_pkg::DIV_N_W-1:0] num_reg;
    logic [ssri_pkg::DIV_D_W-1:0] den_reg;
    logic [ssri_pkg::DIV_D_W:0]   rem_reg;
    logic [ssri_pkg::DIV_N_W-1:0] quo_reg;
    logic [ssri_pkg::STEP_W-1:0]  cnt_reg;
    logic                         busy_reg;

    logic [ssri_pkg::DIV_D_W:0]   rem_sh;
    logic                         take;

    // one quotient bit per cycle, dividend supplied msb aligned
    assign rem_sh = {rem_reg[ssri_pkg::DIV_D_W-1:0], num_reg[ssri_pkg::DIV_N_W-1]};
    assign take   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ssri_pkg::STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[ssri_pkg::DIV_N_W-2:0], 1'b0};
            rem_reg <= take ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[ssri_pkg::DIV_N_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/ssri_sqrt.sv =====
`default_nettype none
module ssri_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ssri_pkg::SQ_W-1:0]  x,
    output logic                            busy,
    output logic [ssri_pkg::SQ_W/2-1:0]     root
);

    logic [ssri_pkg::SQ_W-1:0] x_reg;
    logic [ssri_pkg::SQ_W-1:0] r_reg;
    logic [ssri_pkg::SQ_W-1:0] bit_reg;
    logic                      busy_reg;

    logic [ssri_pkg::SQ_W-1:0] trial;

    // digit by digit root, two radicand bits a cycle
    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (busy_reg && (bit_reg[ssri_pkg::SQ_W-1:2] == '0))
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(ssri_pkg::SQ_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[ssri_pkg::SQ_W/2-1:0];

endmodule
`default_nettype wire

// ===== rtl/ssri_back.sv =====
`default_nettype none
module ssri_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ssri_pkg::job_t head,
    input  wire logic           empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ssri_pkg::out_item_t out_data
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_LOAD = 4'd1;
    localparam logic [3:0] B_MULA = 4'd2;
    localparam logic [3:0] B_MULB = 4'd3;
    localparam logic [3:0] B_DSH  = 4'd4;
    localparam logic [3:0] B_DF   = 4'd5;
    localparam logic [3:0] B_MF1  = 4'd6;
    localparam logic [3:0] B_MF2  = 4'd7;
    localparam logic [3:0] B_MV   = 4'd8;
    localparam logic [3:0] B_DXS  = 4'd9;
    localparam logic [3:0] B_DX   = 4'd10;
    localparam logic [3:0] B_SQ   = 4'd11;
    localparam logic [3:0] B_EMIT = 4'd12;

    logic [3:0]                 state_reg, state_next;
    ssri_pkg::job_t             job_reg;
    logic [2:0]                 slot_reg;
    logic [22:0]                c_reg;
    logic [45:0]                prod_reg;
    logic [45:0]                den_reg;
    logic                       ext_reg;
    logic [16:0]                share_reg;
    logic [38:0]                f_reg;
    logic [49:0]                fx_reg;
    logic [33:0]                dvs_reg;
    logic [24:0]                d_reg;
    logic                       out_valid_reg;
    ssri_pkg::out_item_t        out_reg;

    logic                       div_start;
    logic [ssri_pkg::DIV_N_W-1:0] div_num;
    logic [ssri_pkg::DIV_D_W-1:0] div_den;
    logic [ssri_pkg::STEP_W-1:0]  div_steps;
    logic                       div_busy;
    logic [ssri_pkg::DIV_N_W-1:0] div_q;
    logic                       sq_start;
    logic                       sq_busy;
    logic [24:0]                sq_root;

    logic [22:0]                t;
    logic [22:0]                rest;
    logic [22:0]                cnt_sel;
    logic [39:0]                share_num;
    logic [39:0]                ext_a;
    logic [39:0]                ext_b;
    logic [31:0]                pp;
    logic [25:0]                hi_sum;
    logic                       emit_go;
    logic                       last;

    assign t         = job_reg.total;
    assign rest      = t - c_reg;
    assign cnt_sel   = job_reg.counts[slot_reg];
    assign share_num = {1'b0, c_reg, 16'd0} + {18'd0, t[22:1]};
    assign ext_a     = c_reg * ssri_pkg::EXT_SCALE;
    assign ext_b     = rest * ssri_pkg::EXT_SCALE;
    assign pp        = (state_reg == B_MF1) ? (f_reg[18:0] * ssri_pkg::WALD_MUL)
                                            : (f_reg[38:19] * ssri_pkg::WALD_MUL);
    assign hi_sum    = {9'd0, share_reg} + {1'b0, d_reg};
    assign emit_go   = !out_valid_reg || out_ready;
    assign last      = ({1'b0, slot_reg} + 4'd1) == job_reg.slots;

    // shared divider operands and the root start
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_steps = '0;
        sq_start  = 1'b0;
        case (state_reg)
            B_MULB:
            begin
                div_start = 1'b1;
                div_num   = {share_num, 46'd0};
                div_den   = {23'd0, t};
                div_steps = ssri_pkg::STEP_W'(40);
            end
            B_DSH:
            begin
                div_start = !div_busy && !ext_reg;
                div_num   = {prod_reg, 40'd0};
                div_den   = den_reg;
                div_steps = ssri_pkg::STEP_W'(86);
            end
            B_DXS:
            begin
                div_start = 1'b1;
                div_num   = {fx_reg, 36'd0};
                div_den   = {12'd0, dvs_reg};
                div_steps = ssri_pkg::STEP_W'(50);
            end
            B_DX:
                sq_start = !div_busy;
            default:
            begin
            end
        endcase
    end

    // sequencer over the slots of one checkpoint
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = B_LOAD;
                end
            B_LOAD:  state_next = B_MULA;
            B_MULA:  state_next = B_MULB;
            B_MULB:  state_next = B_DSH;
            B_DSH:
                if (!div_busy)
                    state_next = ext_reg ? B_EMIT : B_DF;
            B_DF:
                if (!div_busy)
                    state_next = B_MF1;
            B_MF1:   state_next = B_MF2;
            B_MF2:   state_next = B_MV;
            B_MV:    state_next = B_DXS;
            B_DXS:   state_next = B_DX;
            B_DX:
                if (!div_busy)
                    state_next = B_SQ;
            B_SQ:
                if (!sq_busy)
                    state_next = B_EMIT;
            B_EMIT:
                if (emit_go)
                    state_next = last ? B_IDLE : B_LOAD;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == B_EMIT) && emit_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg  <= head;
                slot_reg <= 3'd0;
            end
            B_LOAD:
                c_reg <= (cnt_sel > t) ? t : cnt_sel;
            B_MULA:
            begin
                prod_reg <= c_reg * rest;
                ext_reg  <= (ext_a < {17'd0, t});
            end
            B_MULB:
            begin
                den_reg <= t * t;
                if (ext_b < {17'd0, t})
                    ext_reg <= 1'b1;
            end
            B_DSH:
                if (!div_busy)
                begin
                    share_reg <= div_q[16:0];
                    d_reg     <= '0;
                end
            B_DF:
                f_reg <= div_q[38:0];
            B_MF1:
                fx_reg <= {18'd0, pp};
            B_MF2:
                fx_reg <= fx_reg + {pp[30:0], 19'd0};
            B_MV:
                dvs_reg <= job_reg.interval * ssri_pkg::WALD_DIV;
            B_SQ:
                if (!sq_busy)
                    d_reg <= sq_root;
            B_EMIT:
                if (emit_go)
                begin
                    out_reg.checkpoint_index   <= job_reg.index;
                    out_reg.records_seen       <= t;
                    out_reg.slot               <= slot_reg;
                    out_reg.share              <= share_reg;
                    out_reg.share_low          <= ({8'd0, share_reg} > d_reg)
                                                  ? 17'({8'd0, share_reg} - d_reg) : 17'd0;
                    out_reg.share_high         <= (hi_sum > {9'd0, ssri_pkg::ONE_Q16})
                                                  ? ssri_pkg::ONE_Q16 : hi_sum[16:0];
                    out_reg.last_of_checkpoint <= last;
                    slot_reg                   <= slot_reg + 3'd1;
                end
            default:
            begin
            end
        endcase
    end

    ssri_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_q)
    );

    ssri_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (div_q[49:0]),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/scenario_share_running_interval_top.sv =====
// records: one per cycle while the checkpoint queue has room
// checkpoint: popped from the queue, then for each reported slot a load, the serial
//   divider for the share and two further quotients, then the root (only the share
//   division for an extreme share), plus any time the receiver holds off
// two checkpoint snapshots queue between front and back before records stall
// rst_n asynchronous, active low: counts, totals, queue, state and config reset
`default_nettype none
module scenario_share_running_interval_top #(
    parameter int MAX_SCENARIOS = 8,
    parameter int CHECKPOINTS   = 100
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ssri_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ssri_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data
);

    logic [15:0]    interval_reg;
    logic [3:0]     count_reg;
    logic [63:0]    ids_reg;

    logic           q_push;
    ssri_pkg::job_t q_push_job;
    logic           q_pop;
    ssri_pkg::job_t q_head;
    logic           q_full;
    logic           q_empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd1;
            count_reg    <= 4'd1;
            ids_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ssri_pkg::CFG_INTERVAL: interval_reg <= cfg_data[15:0];
                ssri_pkg::CFG_COUNT:    count_reg    <= cfg_data[3:0];
                ssri_pkg::CFG_IDS:      ids_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    ssri_front #(
        .MAX_SCENARIOS (MAX_SCENARIOS),
        .CHECKPOINTS   (CHECKPOINTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_valid && in_ready),
        .item           (in_data),
        .interval       (interval_reg),
        .scenario_count (count_reg),
        .scenario_ids   (ids_reg),
        .push           (q_push),
        .push_job       (q_push_job)
    );

    ssri_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ssri_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // interval bounds enclose the share
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.share_low <= out_data.share)
                   && (out_data.share <= out_data.share_high))
        else $error("interval does not enclose share");

    // shares stay within one and no checkpoint is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.share_high <= ssri_pkg::ONE_Q16)
                   && (out_data.records_seen != '0))
        else $error("share out of range or empty checkpoint");

    // a snapshot is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("checkpoint queue overflow");

    // the back end never takes from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("checkpoint queue underflow");

endmodule
`default_nettype wire
